[design/recs80_enc_pkg.sv]
// Shared types and constants for the RECS80 style infrared frame encoder.
`default_nettype none

package recs80_enc_pkg;

  // Default key code width
  localparam int CODE_BITS_DEF = 11;

  // Widths of the stream fields and settings
  localparam int CODE_W     = 11;
  localparam int CMD_W      = 2;
  localparam int INTERVAL_W = 10;
  localparam int PULSE_W    = 8;
  localparam int GAP_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  // Reset values of the settings
  localparam logic [PULSE_W-1:0]    PULSE_RST = 8'd7;
  localparam logic [INTERVAL_W-1:0] ZERO_RST  = 10'd189;
  localparam logic [INTERVAL_W-1:0] ONE_RST   = 10'd287;
  localparam logic [GAP_W-1:0]      GAP_RST   = 8'd10;

  // Commands carried on the input tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_TICK   = 2'd0,
    CMD_SEND   = 2'd1,
    CMD_REPEAT = 2'd2,
    CMD_STOP   = 2'd3
  } cmd_t;

  // Settings register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PULSE = 2'd0,
    REG_ZERO  = 2'd1,
    REG_ONE   = 2'd2,
    REG_GAP   = 2'd3
  } reg_idx_t;

  // Frame phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_BIT_A = 3'd1,
    PH_BIT_B = 3'd2,
    PH_STOP  = 3'd3,
    PH_WAIT  = 3'd4
  } phase_t;

endpackage

`default_nettype wire

[design/recs80_ir_frame_encoder.sv]
// RECS80 style pulse-distance infrared frame encoder with stream ports.
// Each input transfer writes its result into the output register.
// Throughput: one command per cycle when not stalled; the whole state update is a
// single pass of logic from the input port into the state and output registers.
// The input is stalled only while the output register holds an untaken result.
// Reset (synchronous, rst high) returns to idle, toggle set, settings at defaults.
`default_nettype none

module recs80_ir_frame_encoder #(
  parameter int CODE_BITS = recs80_enc_pkg::CODE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,

  // Command stream
  input  wire logic                                   s_axis_tvalid,
  output      logic                                   s_axis_tready,
  // [10:0] code, [15:11] zero
  input  wire logic [recs80_enc_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [1:0] command
  input  wire logic [recs80_enc_pkg::CMD_W-1:0]       s_axis_tuser,

  // Result stream
  output      logic                                   m_axis_tvalid,
  input  wire logic                                   m_axis_tready,
  // [0] carrier_on, [10:1] interval_ticks, [11] busy_res, [12] frame_started,
  // [15:13] zero
  output      logic [recs80_enc_pkg::OUT_DATA_W-1:0]  m_axis_tdata,

  // Settings write channel
  input  wire logic                                   cfg_valid,
  output      logic                                   cfg_ready,
  input  wire logic [recs80_enc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [recs80_enc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int BCW = $clog2(CODE_BITS + 1);
  localparam int IW  = recs80_enc_pkg::INTERVAL_W;
  localparam int GW  = recs80_enc_pkg::GAP_W;
  localparam int PW  = recs80_enc_pkg::PULSE_W;

  // Settings
  logic [PW-1:0] pulse_ticks;
  logic [IW-1:0] zero_space_ticks;
  logic [IW-1:0] one_space_ticks;
  logic [GW-1:0] gap_intervals;

  // Encoder state
  recs80_enc_pkg::phase_t phase, phase_next;
  logic [CODE_BITS-1:0] shift_code, shift_code_next;
  logic [CODE_BITS-1:0] active_code, active_code_next;
  logic [BCW-1:0]       bit_count, bit_count_next;
  logic [GW-1:0]        gap_count, gap_count_next;
  logic                 toggle_bit, toggle_bit_next;
  logic [IW-1:0]        interval_reg, interval_reg_next;
  logic                 carrier_reg, carrier_reg_next;
  logic                 started;

  // Output register
  logic                 out_valid;
  logic                 out_carrier;
  logic [IW-1:0]        out_interval;
  logic                 out_busy;
  logic                 out_started;

  logic                 in_fire;
  recs80_enc_pkg::cmd_t cmd;
  logic [CODE_BITS-1:0] code_ext;
  logic [CODE_BITS-1:0] code_toggled;
  logic [BCW-1:0]       bit_inc;
  logic [GW-1:0]        gap_inc;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign cmd          = recs80_enc_pkg::cmd_t'(s_axis_tuser);
  assign code_ext     = CODE_BITS'(s_axis_tdata[recs80_enc_pkg::CODE_W-1:0]);
  assign code_toggled = code_ext | (toggle_bit ? (CODE_BITS'(1) << (CODE_BITS - 2))
                                               : '0);
  assign bit_inc      = bit_count + BCW'(1);
  assign gap_inc      = gap_count + GW'(1);

  // Settings writes
  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_ticks      <= recs80_enc_pkg::PULSE_RST;
      zero_space_ticks <= recs80_enc_pkg::ZERO_RST;
      one_space_ticks  <= recs80_enc_pkg::ONE_RST;
      gap_intervals    <= recs80_enc_pkg::GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (recs80_enc_pkg::reg_idx_t'(cfg_index))
        recs80_enc_pkg::REG_PULSE: pulse_ticks      <= cfg_data[PW-1:0];
        recs80_enc_pkg::REG_ZERO:  zero_space_ticks <= cfg_data[IW-1:0];
        recs80_enc_pkg::REG_ONE:   one_space_ticks  <= cfg_data[IW-1:0];
        recs80_enc_pkg::REG_GAP:   gap_intervals    <= cfg_data[GW-1:0];
        default: ;
      endcase
    end
  end

  // Next state for one command
  always_comb begin
    phase_next        = phase;
    shift_code_next   = shift_code;
    active_code_next  = active_code;
    bit_count_next    = bit_count;
    gap_count_next    = gap_count;
    toggle_bit_next   = toggle_bit;
    interval_reg_next = interval_reg;
    carrier_reg_next  = carrier_reg;
    started           = 1'b0;

    unique case (cmd)
      recs80_enc_pkg::CMD_TICK: begin
        unique case (phase)
          recs80_enc_pkg::PH_IDLE: begin
            carrier_reg_next = 1'b0;
          end
          recs80_enc_pkg::PH_BIT_A: begin
            interval_reg_next = IW'(pulse_ticks);
            carrier_reg_next  = 1'b1;
            phase_next        = recs80_enc_pkg::PH_BIT_B;
          end
          recs80_enc_pkg::PH_STOP: begin
            interval_reg_next = IW'(pulse_ticks);
            carrier_reg_next  = 1'b1;
            phase_next        = recs80_enc_pkg::PH_WAIT;
          end
          recs80_enc_pkg::PH_BIT_B: begin
            carrier_reg_next  = 1'b0;
            interval_reg_next = shift_code[CODE_BITS-1] ? one_space_ticks
                                                        : zero_space_ticks;
            shift_code_next   = shift_code << 1;
            bit_count_next    = bit_inc;
            phase_next        = (bit_inc >= BCW'(CODE_BITS)) ? recs80_enc_pkg::PH_STOP
                                                             : recs80_enc_pkg::PH_BIT_A;
          end
          recs80_enc_pkg::PH_WAIT: begin
            carrier_reg_next  = 1'b0;
            interval_reg_next = zero_space_ticks;
            gap_count_next    = gap_inc;
            if (gap_inc >= gap_intervals) begin
              bit_count_next = '0;
              gap_count_next = '0;
              phase_next     = recs80_enc_pkg::PH_IDLE;
            end
          end
          default: begin
            carrier_reg_next = 1'b0;
            bit_count_next   = '0;
            gap_count_next   = '0;
            phase_next       = recs80_enc_pkg::PH_IDLE;
          end
        endcase
      end
      recs80_enc_pkg::CMD_SEND: begin
        active_code_next = code_toggled;
        if ((code_toggled != '0) && (phase == recs80_enc_pkg::PH_IDLE)) begin
          shift_code_next = code_toggled;
          phase_next      = recs80_enc_pkg::PH_BIT_A;
          started         = 1'b1;
        end
      end
      recs80_enc_pkg::CMD_REPEAT: begin
        if ((active_code != '0) && (phase == recs80_enc_pkg::PH_IDLE)) begin
          shift_code_next = active_code;
          phase_next      = recs80_enc_pkg::PH_BIT_A;
          started         = 1'b1;
        end
      end
      recs80_enc_pkg::CMD_STOP: begin
        toggle_bit_next = !toggle_bit;
      end
      default: ;
    endcase
  end

  // State register, updated on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= recs80_enc_pkg::PH_IDLE;
      shift_code   <= '0;
      active_code  <= '0;
      bit_count    <= '0;
      gap_count    <= '0;
      toggle_bit   <= 1'b1;
      interval_reg <= IW'(recs80_enc_pkg::PULSE_RST);
      carrier_reg  <= 1'b0;
    end else if (in_fire) begin
      phase        <= phase_next;
      shift_code   <= shift_code_next;
      active_code  <= active_code_next;
      bit_count    <= bit_count_next;
      gap_count    <= gap_count_next;
      toggle_bit   <= toggle_bit_next;
      interval_reg <= interval_reg_next;
      carrier_reg  <= carrier_reg_next;
    end
  end

  // Output register valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_carrier  <= carrier_reg_next;
      out_interval <= interval_reg_next;
      out_busy     <= (phase_next != recs80_enc_pkg::PH_IDLE);
      out_started  <= started;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_started, out_busy, out_interval, out_carrier};

`ifndef SYNTHESIS
  // A result that reports a new frame must also report the encoder busy.
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_started || out_busy))
    else $error("frame start reported while not busy");

  // A started frame begins with the first carrier pulse phase.
  a_start_phase: assert property (@(posedge clk) disable iff (rst)
    (in_fire && started) |=> (phase == recs80_enc_pkg::PH_BIT_A))
    else $error("frame start did not enter the first bit phase");

  // The bit counter never runs past the code width.
  a_bit_range: assert property (@(posedge clk) disable iff (rst)
    bit_count <= BCW'(CODE_BITS))
    else $error("bit counter beyond code width");

  // Counters are cleared whenever the encoder is idle.
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == recs80_enc_pkg::PH_IDLE) |-> (bit_count == '0 && gap_count == '0))
    else $error("counters not cleared in idle");

  // The carrier is only on during a pulse interval.
  a_carrier_phase: assert property (@(posedge clk) disable iff (rst)
    carrier_reg |-> (phase == recs80_enc_pkg::PH_BIT_B ||
                     phase == recs80_enc_pkg::PH_WAIT))
    else $error("carrier on outside a pulse interval");
`endif

endmodule

`default_nettype wire
